### rtl/ssp_pkg.sv
// Shared constants, codes and payload types for the shortest path core.
package ssp_pkg;

    localparam int MAX_NODES   = 64;
    localparam int MAX_EDGES   = 256;
    localparam int WEIGHT_BITS = 16;

    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int NCNT_W      = NODE_W + 1;
    localparam int EDGE_AW     = $clog2(MAX_EDGES);
    localparam int ECNT_W      = EDGE_AW + 1;
    localparam int DIST_W      = 31;
    localparam int DIST_RAM_W  = DIST_W + 1;
    localparam int CFG_W       = 7;

    localparam logic [DIST_W-1:0] UNREACHED = 31'h7FFF_FFFF;
    localparam logic [DIST_W-1:0] SUM_CAP   = 31'h7FFF_FFFE;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic {
        CMD_ADD = 1'b0,
        CMD_RUN = 1'b1
    } cmd_t;

    typedef struct packed {
        logic        command;
        logic [5:0]  from_node;
        logic [5:0]  to_node;
        logic [15:0] weight;
        logic        one_way;
        logic [5:0]  source_node;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  node;
        logic [30:0] distance;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [NODE_W-1:0]      tail;
        logic [NODE_W-1:0]      head;
        logic [WEIGHT_BITS-1:0] weight;
    } edge_t;

    localparam int EDGE_W = $bits(edge_t);

endpackage

### rtl/ssp_if.sv
// Request and result channel interfaces of the shortest path core.
interface ssp_req_if import ssp_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ssp_rsp_if import ssp_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/single_source_shortest_paths_core.sv
// Dijkstra shortest path core: top level with edge table, distance RAM and sequencer.
// Add edge: status result the next cycle; a two-way add also writes the reverse edge in ST_ADD2.
// Run: accept, init of n distances, then per settled node a scan of n distances, a read and
// check of every stored edge (plus an update when it leaves that node to a node below n), a closing
// step, a last scan, then one read and one result per node; bad source skips the search.
// Bound by the distance RAM read port; one request at a time. Reset: table empty, count 64.
module single_source_shortest_paths_core import ssp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    ssp_req_if.sink            req,
    ssp_rsp_if.source          rsp
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD2,
        ST_INIT,
        ST_SCAN,
        ST_REDGE,
        ST_RCHK,
        ST_RUPD,
        ST_ORD,
        ST_OLD
    } state_t;

    state_t              state_reg;
    logic [CFG_W-1:0]    node_count_reg;
    logic [ECNT_W-1:0]   edge_total_reg;
    logic [ECNT_W-1:0]   edge_cnt_reg;
    logic [NCNT_W-1:0]   n_reg;
    logic [NCNT_W-1:0]   scan_cnt_reg;
    logic [NCNT_W-1:0]   out_cnt_reg;
    logic [NODE_W-1:0]   src_reg;
    logic [NODE_W-1:0]   rd_idx_reg;
    logic                rd_vld_reg;
    logic [NODE_W-1:0]   pick_reg;
    logic                pick_found_reg;
    logic [DIST_W-1:0]   pd_reg;
    logic                bad_reg;
    edge_t               add2_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_data_reg;

    logic                edge_we;
    logic [EDGE_AW-1:0]  edge_waddr;
    edge_t               edge_wdata;
    edge_t               edge_rd;
    logic [EDGE_W-1:0]   edge_rdata;

    logic                 dist_we;
    logic [NODE_W-1:0]    dist_waddr;
    logic [DIST_RAM_W-1:0] dist_wdata;
    logic [NODE_W-1:0]    dist_raddr;
    logic [DIST_RAM_W-1:0] dist_rdata;
    logic [DIST_W-1:0]    dist_rd_val;
    logic                 dist_rd_done;

    logic                rsp_free;
    logic                rsp_load;
    logic                req_fire;
    req_t                rq;
    logic                add_range;
    logic [ECNT_W:0]     add_need_total;
    logic                add_full;
    logic                add_ok;
    logic [NCNT_W-1:0]   run_n;
    logic                scan_done;
    logic                edge_hit;
    logic [DIST_W:0]     relax_sum;
    logic [DIST_W-1:0]   relax_cap;

    assign rq       = req.data;
    assign rsp_free = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && rsp_free;
    assign req_fire = req.valid && req.ready;
    assign rsp_load = (req_fire && rq.command == CMD_ADD)
                   || (state_reg == ST_OLD && rsp_free);

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    assign edge_rd = edge_t'(edge_rdata);

    // top bit of a distance word is the settled mark
    assign dist_rd_val  = dist_rdata[DIST_W-1:0];
    assign dist_rd_done = dist_rdata[DIST_W];

    assign scan_done = (state_reg == ST_SCAN) && (scan_cnt_reg == n_reg) && !rd_vld_reg;

    always_comb
    begin
        add_range = ({1'b0, rq.from_node} >= NCNT_W'(MAX_NODES))
                 || ({1'b0, rq.to_node} >= NCNT_W'(MAX_NODES));
        add_need_total = {1'b0, edge_total_reg} + (rq.one_way ? (ECNT_W+1)'(1)
                                                              : (ECNT_W+1)'(2));
        add_full = add_need_total > (ECNT_W+1)'(MAX_EDGES);
        add_ok   = !add_range && !add_full;
        if (node_count_reg == '0)
        begin
            run_n = NCNT_W'(1);
        end
        else if (node_count_reg > CFG_W'(MAX_NODES))
        begin
            run_n = NCNT_W'(MAX_NODES);
        end
        else
        begin
            run_n = NCNT_W'(node_count_reg);
        end
        edge_hit  = (edge_rd.tail == pick_reg) && ({1'b0, edge_rd.head} < n_reg);
        relax_sum = {1'b0, pd_reg} + (DIST_W+1)'(edge_rd.weight);
        relax_cap = (relax_sum > {1'b0, SUM_CAP}) ? SUM_CAP : relax_sum[DIST_W-1:0];
    end

    always_comb
    begin
        edge_we    = 1'b0;
        edge_waddr = edge_total_reg[EDGE_AW-1:0];
        edge_wdata = add2_reg;
        if (state_reg == ST_ADD2)
        begin
            edge_we = 1'b1;
        end
        else if (req_fire && rq.command == CMD_ADD && add_ok)
        begin
            edge_we    = 1'b1;
            edge_wdata = '{tail: rq.from_node, head: rq.to_node,
                           weight: rq.weight[WEIGHT_BITS-1:0]};
        end
    end

    always_comb
    begin
        dist_we    = 1'b0;
        dist_waddr = scan_cnt_reg[NODE_W-1:0];
        dist_wdata = {1'b0, ((scan_cnt_reg[NODE_W-1:0] == src_reg) ? DIST_W'(0)
                                                                    : UNREACHED)};
        case (state_reg)
            ST_INIT:
            begin
                dist_we = 1'b1;
            end
            ST_SCAN:
            begin
                dist_we    = scan_done && pick_found_reg;
                dist_waddr = pick_reg;
                dist_wdata = {1'b1, pd_reg};
            end
            ST_RUPD:
            begin
                dist_we    = relax_cap < dist_rd_val;
                dist_waddr = edge_rd.head;
                dist_wdata = {dist_rd_done, relax_cap};
            end
            default:
            begin
                dist_we = 1'b0;
            end
        endcase
        case (state_reg)
            ST_SCAN:           dist_raddr = scan_cnt_reg[NODE_W-1:0];
            ST_RCHK, ST_RUPD:  dist_raddr = edge_rd.head;
            default:           dist_raddr = out_cnt_reg[NODE_W-1:0];
        endcase
    end

    ssp_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_cnt_reg[EDGE_AW-1:0]),
        .rdata (edge_rdata)
    );

    ssp_ram #(
        .WIDTH (DIST_RAM_W),
        .DEPTH (MAX_NODES)
    ) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= CFG_W'(MAX_NODES);
            edge_total_reg <= '0;
            edge_cnt_reg   <= '0;
            n_reg          <= NCNT_W'(1);
            scan_cnt_reg   <= '0;
            out_cnt_reg    <= '0;
            src_reg        <= '0;
            rd_idx_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            pick_reg       <= '0;
            pick_found_reg <= 1'b0;
            pd_reg         <= UNREACHED;
            bad_reg        <= 1'b0;
            add2_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_data_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        if (rq.command == CMD_ADD)
                        begin
                            rsp_data_reg.node     <= '0;
                            rsp_data_reg.distance <= '0;
                            rsp_data_reg.last     <= 1'b1;
                            add2_reg <= '{tail: rq.to_node, head: rq.from_node,
                                          weight: rq.weight[WEIGHT_BITS-1:0]};
                            if (add_range)
                            begin
                                rsp_data_reg.status <= STATUS_RANGE;
                            end
                            else if (add_full)
                            begin
                                rsp_data_reg.status <= STATUS_FULL;
                            end
                            else
                            begin
                                rsp_data_reg.status <= STATUS_OK;
                                edge_total_reg <= edge_total_reg + ECNT_W'(1);
                                if (!rq.one_way)
                                begin
                                    state_reg <= ST_ADD2;
                                end
                            end
                        end
                        else
                        begin
                            n_reg        <= run_n;
                            src_reg      <= rq.source_node;
                            scan_cnt_reg <= '0;
                            out_cnt_reg  <= '0;
                            if ({1'b0, rq.source_node} >= run_n)
                            begin
                                bad_reg   <= 1'b1;
                                state_reg <= ST_ORD;
                            end
                            else
                            begin
                                bad_reg   <= 1'b0;
                                state_reg <= ST_INIT;
                            end
                        end
                    end
                end

                ST_ADD2:
                begin
                    edge_total_reg <= edge_total_reg + ECNT_W'(1);
                    state_reg      <= ST_IDLE;
                end

                ST_INIT:
                begin
                    if (scan_cnt_reg == n_reg - NCNT_W'(1))
                    begin
                        scan_cnt_reg   <= '0;
                        rd_vld_reg     <= 1'b0;
                        pd_reg         <= UNREACHED;
                        pick_found_reg <= 1'b0;
                        state_reg      <= ST_SCAN;
                    end
                    else
                    begin
                        scan_cnt_reg <= scan_cnt_reg + NCNT_W'(1);
                    end
                end

                ST_SCAN:
                begin
                    rd_vld_reg <= scan_cnt_reg < n_reg;
                    rd_idx_reg <= scan_cnt_reg[NODE_W-1:0];
                    if (scan_cnt_reg < n_reg)
                    begin
                        scan_cnt_reg <= scan_cnt_reg + NCNT_W'(1);
                    end
                    if (rd_vld_reg && !dist_rd_done && dist_rd_val < pd_reg)
                    begin
                        pd_reg         <= dist_rd_val;
                        pick_reg       <= rd_idx_reg;
                        pick_found_reg <= 1'b1;
                    end
                    if (scan_done)
                    begin
                        if (pick_found_reg)
                        begin
                            edge_cnt_reg <= '0;
                            state_reg    <= ST_REDGE;
                        end
                        else
                        begin
                            out_cnt_reg <= '0;
                            state_reg   <= ST_ORD;
                        end
                    end
                end

                ST_REDGE:
                begin
                    if (edge_cnt_reg == edge_total_reg)
                    begin
                        scan_cnt_reg   <= '0;
                        rd_vld_reg     <= 1'b0;
                        pd_reg         <= UNREACHED;
                        pick_found_reg <= 1'b0;
                        state_reg      <= ST_SCAN;
                    end
                    else
                    begin
                        state_reg <= ST_RCHK;
                    end
                end

                ST_RCHK:
                begin
                    if (edge_hit)
                    begin
                        state_reg <= ST_RUPD;
                    end
                    else
                    begin
                        edge_cnt_reg <= edge_cnt_reg + ECNT_W'(1);
                        state_reg    <= ST_REDGE;
                    end
                end

                ST_RUPD:
                begin
                    edge_cnt_reg <= edge_cnt_reg + ECNT_W'(1);
                    state_reg    <= ST_REDGE;
                end

                ST_ORD:
                begin
                    state_reg <= ST_OLD;
                end

                ST_OLD:
                begin
                    if (rsp_free)
                    begin
                        rsp_data_reg.status   <= bad_reg ? STATUS_RANGE : STATUS_OK;
                        rsp_data_reg.node     <= out_cnt_reg[NODE_W-1:0];
                        rsp_data_reg.distance <= bad_reg ? UNREACHED : dist_rd_val;
                        rsp_data_reg.last     <= (out_cnt_reg + NCNT_W'(1)) == n_reg;
                        if ((out_cnt_reg + NCNT_W'(1)) == n_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            out_cnt_reg <= out_cnt_reg + NCNT_W'(1);
                            state_reg   <= ST_ORD;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/ssp_ram.sv
// Generic simple dual-port RAM with registered read.
module ssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
